/* sv/nvpu_pkg.sv */
// Shared types and constants for the nibble video packet unpacker.
// No dependencies; every other file imports this package.
package nvpu_pkg;

  localparam int HDR_BYTES = 12;
  localparam int HDR_IW    = 4;
  localparam int ADDR_W    = 17;
  localparam int LEN_W     = 12;
  localparam int NEED_W    = 25;
  localparam int FW_W      = 9;
  localparam int FRAME_W   = 16;

  localparam int HB_FRAME_LO = 2;
  localparam int HB_FRAME_HI = 3;
  localparam int HB_LINE_LO  = 4;
  localparam int HB_LINE_HI  = 5;
  localparam int HB_WIDTH_LO = 6;
  localparam int HB_WIDTH_HI = 7;
  localparam int HB_LINES    = 8;
  localparam int HB_BPP      = 9;
  localparam int HB_ENC_LO   = 10;

  localparam logic [7:0]         BPP_NIBBLE   = 8'd4;
  localparam logic [7:0]         ENC_PACKED   = 8'd0;
  localparam logic [FW_W-1:0]    WIDTH_RESET  = 9'd384;
  localparam int                 HEIGHT_RESET = 272;
  localparam logic [FRAME_W-1:0] FRAME_RESET  = 16'hFFFF;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [31:0] PALETTE [16] = '{
    32'hFF000000, 32'hFFFFFFFF, 32'hFF813338, 32'hFF75CEC8,
    32'hFF8E3C97, 32'hFF56AC4D, 32'hFF2E2C9B, 32'hFFEDF171,
    32'hFF8E5029, 32'hFF553800, 32'hFFC46C71, 32'hFF4A4A4A,
    32'hFF7B7B7B, 32'hFFA9FF9F, 32'hFF706DEB, 32'hFFB2B2B2
  };

  typedef struct packed {
    logic [1:0]         n_pix;
    logic [ADDR_W-1:0]  addr;
    logic [3:0]         nib_lo;
    logic [3:0]         nib_hi;
    logic               is_end;
    logic               accepted;
    logic               last_pkt;
    logic [FRAME_W-1:0] frame;
    logic [7:0]         lines;
    logic [FW_W-1:0]    width;
    logic [15:0]        height;
  } nvpu_cmd_t;

endpackage

/* sv/nvpu_front.sv */
// Front end: byte counting, header capture and check, pixel address generation.
// Depends on nvpu_pkg; feeds commands into nvpu_queue.
module nvpu_front
  import nvpu_pkg::*;
#(
  parameter int MAX_WIDTH        = 384,
  parameter int MAX_HEIGHT       = 312,
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic [LEN_W-1:0] in_packet_length,
  input  logic             q_full,
  output logic             push,
  output nvpu_cmd_t        cmd
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES);
  localparam int COL_W = $clog2(MAX_WIDTH + 2);
  localparam int ENDW  = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              hv_r, hv_nxt;
  logic [7:0]        row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [7:0]        hdr_r [HDR_BYTES];
  logic [NEED_W-1:0] need_r;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;

  logic              accept, at_end, in_hdr, hdr_done, hdr_check, hv_now;
  logic              active, second, row_wrap;
  logic [LEN_W-1:0]  len_c;
  logic [15:0]       hdr_width, hdr_frame;
  logic [14:0]       hdr_line;
  logic [7:0]        hdr_lines;
  logic [16:0]       wp1;
  logic [COL_W-1:0]  col_step;

  always_comb begin
    accept    = in_valid && !q_full;
    in_stall  = q_full;
    hdr_width = {hdr_r[HB_WIDTH_HI], hdr_r[HB_WIDTH_LO]};
    hdr_frame = {hdr_r[HB_FRAME_HI], hdr_r[HB_FRAME_LO]};
    hdr_line  = {hdr_r[HB_LINE_HI][6:0], hdr_r[HB_LINE_LO]};
    hdr_lines = hdr_r[HB_LINES];
    wp1       = {1'b0, hdr_width} + 17'd1;

    len_c = in_packet_length;
    if (len_c == '0) begin
      len_c = LEN_W'(1);
    end
    if (int'(len_c) > MAX_PACKET_BYTES) begin
      len_c = LEN_W'(MAX_PACKET_BYTES);
    end
    at_end   = (ENDW'(pos_r) + ENDW'(1)) >= ENDW'(len_c);
    in_hdr   = pos_r < POS_W'(HDR_BYTES);
    hdr_done = pos_r == POS_W'(HDR_BYTES - 1);

    hdr_check = (hdr_r[HB_BPP] == BPP_NIBBLE) && (hdr_r[HB_ENC_LO] == ENC_PACKED) &&
                (in_data_byte == ENC_PACKED) && (hdr_width != '0) &&
                (int'(hdr_width) <= MAX_WIDTH) && (hdr_lines != '0) &&
                (int'({1'b0, hdr_line} + 16'(hdr_lines)) <= MAX_HEIGHT) &&
                (NEED_W'(len_c) >= need_r);
    hv_now = hdr_done ? hdr_check : hv_r;

    active   = !in_hdr && hv_r && (row_r < hdr_lines);
    second   = (16'(col_r) + 16'd1) < hdr_width;
    col_step = col_r + COL_W'(2);
    row_wrap = 16'(col_step) >= hdr_width;

    cmd.n_pix    = active ? (second ? 2'd2 : 2'd1) : 2'd0;
    cmd.addr     = row_base_r + ADDR_W'(col_r);
    cmd.nib_lo   = in_data_byte[3:0];
    cmd.nib_hi   = in_data_byte[7:4];
    cmd.is_end   = at_end;
    cmd.accepted = hv_now;
    cmd.last_pkt = hdr_r[HB_LINE_HI][7];
    cmd.frame    = hdr_frame;
    cmd.lines    = hdr_lines;
    cmd.width    = hdr_width[FW_W-1:0];
    cmd.height   = {1'b0, hdr_line} + 16'(hdr_lines);

    push = accept && (active || at_end);

    pos_nxt      = pos_r;
    hv_nxt       = hv_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    row_base_nxt = row_base_r;
    if (accept) begin
      if (hdr_done) begin
        hv_nxt  = hdr_check;
        row_nxt = '0;
        col_nxt = '0;
      end
      if (pos_r == POS_W'(HB_BPP)) begin
        row_base_nxt = ADDR_W'(32'(hdr_line) * MAX_WIDTH);
      end
      if (active) begin
        if (row_wrap) begin
          col_nxt      = '0;
          row_nxt      = row_r + 8'd1;
          row_base_nxt = row_base_r + ADDR_W'(MAX_WIDTH);
        end else begin
          col_nxt = col_step;
        end
      end
      if (at_end) begin
        pos_nxt = '0;
        hv_nxt  = 1'b0;
        row_nxt = '0;
        col_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hv_r  <= 1'b0;
      row_r <= '0;
      col_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      hv_r  <= hv_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_base_r <= row_base_nxt;
    if (accept && in_hdr) begin
      hdr_r[pos_r[HDR_IW-1:0]] <= in_data_byte;
    end
    if (accept && pos_r == POS_W'(HB_BPP)) begin
      need_r <= NEED_W'(wp1[16:1]) * NEED_W'(hdr_lines) + NEED_W'(HDR_BYTES);
    end
  end

  a_valid_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r |-> !in_hdr)
    else $error("header flagged valid while still inside the header");

endmodule

/* sv/nvpu_queue.sv */
// Short command queue between the front and back ends.
// Depends on nvpu_pkg for the command type.
module nvpu_queue
  import nvpu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  nvpu_cmd_t push_data,
  input  logic      pop,
  output nvpu_cmd_t head,
  output logic      full,
  output logic      empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  nvpu_cmd_t      slot_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    full  = cnt_r == CW'(DEPTH);
    empty = cnt_r == '0;
    head  = slot_r[rd_r];
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("command popped from an empty queue");

endmodule

/* sv/nvpu_back.sv */
// Back end: expands commands into pixel writes and status, keeps frame tracking.
// Depends on nvpu_pkg; reads commands from nvpu_queue.
module nvpu_back
  import nvpu_pkg::*;
#(
  parameter int MAX_HEIGHT = 312
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nvpu_cmd_t          head,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_result_kind,
  output logic [ADDR_W-1:0]  out_pixel_address,
  output logic [31:0]        out_pixel_color,
  output logic               out_packet_accepted,
  output logic               out_frame_ready,
  output logic               out_frame_complete,
  output logic [FW_W-1:0]    out_frame_width,
  output logic [FW_W-1:0]    out_frame_height,
  output logic [FRAME_W-1:0] out_frame_number,
  output logic               out_last_result
);

  localparam int HT_RAW = $clog2(MAX_HEIGHT + 1);
  localparam int HT_W   = (HT_RAW > FW_W) ? HT_RAW : FW_W;

  logic [1:0]         step_r, step_nxt;
  logic               ov_r, ov_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [15:0]        lrcv_r, lrcv_nxt;
  logic               ready_r, ready_nxt;
  logic               compl_r, compl_nxt;
  logic [FW_W-1:0]    wseen_r, wseen_nxt;
  logic [HT_W-1:0]    hseen_r, hseen_nxt;

  logic               kind_r, kind_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [31:0]        color_r, color_nxt;
  logic               acc_r, acc_nxt;
  logic               ordy_r, ordy_nxt;
  logic               ocmp_r, ocmp_nxt;
  logic [FW_W-1:0]    ow_r, ow_nxt;
  logic [FW_W-1:0]    oh_r, oh_nxt;
  logic [FRAME_W-1:0] ofr_r, ofr_nxt;
  logic               last_r, last_nxt;

  logic               load, emit, is_pix, fin, new_frame;
  logic [1:0]         n_res;
  logic [15:0]        lr_upd;
  logic [3:0]         nib;

  always_comb begin
    load      = !ov_r || !out_stall;
    emit      = load && !q_empty;
    n_res     = head.n_pix + {1'b0, head.is_end};
    is_pix    = step_r < head.n_pix;
    fin       = (step_r + 2'd1) == n_res;
    pop       = emit && fin;
    new_frame = head.frame != frame_r;
    lr_upd    = (new_frame ? 16'd0 : lrcv_r) + 16'(head.lines);
    nib       = (step_r == 2'd0) ? head.nib_lo : head.nib_hi;

    step_nxt  = step_r;
    ov_nxt    = load ? !q_empty : ov_r;
    frame_nxt = frame_r;
    lrcv_nxt  = lrcv_r;
    ready_nxt = ready_r;
    compl_nxt = compl_r;
    wseen_nxt = wseen_r;
    hseen_nxt = hseen_r;

    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    color_nxt = color_r;
    acc_nxt   = acc_r;
    ordy_nxt  = ordy_r;
    ocmp_nxt  = ocmp_r;
    ow_nxt    = ow_r;
    oh_nxt    = oh_r;
    ofr_nxt   = ofr_r;
    last_nxt  = last_r;

    if (emit) begin
      step_nxt = fin ? 2'd0 : step_r + 2'd1;
      last_nxt = fin;
      if (is_pix) begin
        kind_nxt  = KIND_PIXEL;
        addr_nxt  = (step_r == 2'd0) ? head.addr : head.addr + ADDR_W'(1);
        color_nxt = PALETTE[nib];
        acc_nxt   = 1'b0;
        ordy_nxt  = 1'b0;
        ocmp_nxt  = 1'b0;
        ow_nxt    = '0;
        oh_nxt    = '0;
        ofr_nxt   = '0;
      end else begin
        if (head.accepted) begin
          frame_nxt = head.frame;
          lrcv_nxt  = lr_upd;
          ready_nxt = new_frame ? 1'b0 : ready_r;
          wseen_nxt = head.width;
          if (head.last_pkt) begin
            hseen_nxt = HT_W'(head.height);
            ready_nxt = 1'b1;
            compl_nxt = lr_upd >= head.height;
          end
        end
        kind_nxt  = KIND_STATUS;
        addr_nxt  = '0;
        color_nxt = '0;
        acc_nxt   = head.accepted;
        ordy_nxt  = ready_nxt;
        ocmp_nxt  = compl_nxt;
        ow_nxt    = wseen_nxt;
        oh_nxt    = hseen_nxt[FW_W-1:0];
        ofr_nxt   = frame_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      ov_r    <= 1'b0;
      frame_r <= FRAME_RESET;
      lrcv_r  <= '0;
      ready_r <= 1'b0;
      compl_r <= 1'b0;
      wseen_r <= WIDTH_RESET;
      hseen_r <= HT_W'(HEIGHT_RESET);
    end else begin
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
      frame_r <= frame_nxt;
      lrcv_r  <= lrcv_nxt;
      ready_r <= ready_nxt;
      compl_r <= compl_nxt;
      wseen_r <= wseen_nxt;
      hseen_r <= hseen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    addr_r  <= addr_nxt;
    color_r <= color_nxt;
    acc_r   <= acc_nxt;
    ordy_r  <= ordy_nxt;
    ocmp_r  <= ocmp_nxt;
    ow_r    <= ow_nxt;
    oh_r    <= oh_nxt;
    ofr_r   <= ofr_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid           = ov_r;
  assign out_result_kind     = kind_r;
  assign out_pixel_address   = addr_r;
  assign out_pixel_color     = color_r;
  assign out_packet_accepted = acc_r;
  assign out_frame_ready     = ordy_r;
  assign out_frame_complete  = ocmp_r;
  assign out_frame_width     = ow_r;
  assign out_frame_height    = oh_r;
  assign out_frame_number    = ofr_r;
  assign out_last_result     = last_r;

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && kind_r == KIND_STATUS) |-> last_r)
    else $error("status result not marked as final result of its byte");

  a_step_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 2'd0) |-> !q_empty)
    else $error("partly expanded command lost from queue head");

endmodule

/* sv/nibble_video_packet_unpacker_unit.sv */
// Top level of the nibble video packet unpacker: front end, command queue, back end.
// Depends on nvpu_pkg, nvpu_front, nvpu_queue and nvpu_back.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   in_data_byte, in_packet_length
// out      out  out_valid / out_stall out_result_kind .. out_last_result (10 fields)
//
// The front takes one byte per cycle while the command queue has room.
// The back emits one result per cycle unless stalled: each accepted payload byte gives
// 1 or 2 pixels, a packet's last byte one more for status; header and ignored bytes none.
// Sustained rate is set by the single result port of the back end.
// Synchronous active-low reset clears counters, queue and frame tracking.
// out_stall holds the output register; once the queue fills, in_stall rises.
module nibble_video_packet_unpacker_unit
  import nvpu_pkg::*;
#(
  parameter int MAX_WIDTH        = 384,
  parameter int MAX_HEIGHT       = 312,
  parameter int MAX_PACKET_BYTES = 2048,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic [LEN_W-1:0]   in_packet_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_result_kind,
  output logic [ADDR_W-1:0]  out_pixel_address,
  output logic [31:0]        out_pixel_color,
  output logic               out_packet_accepted,
  output logic               out_frame_ready,
  output logic               out_frame_complete,
  output logic [FW_W-1:0]    out_frame_width,
  output logic [FW_W-1:0]    out_frame_height,
  output logic [FRAME_W-1:0] out_frame_number,
  output logic               out_last_result
);

  nvpu_cmd_t push_cmd, head_cmd;
  logic      push, pop, q_full, q_empty;

  nvpu_front #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_packet_length(in_packet_length),
    .q_full          (q_full),
    .push            (push),
    .cmd             (push_cmd)
  );

  nvpu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  nvpu_back #(
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head_cmd),
    .q_empty            (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_pixel_address  (out_pixel_address),
    .out_pixel_color    (out_pixel_color),
    .out_packet_accepted(out_packet_accepted),
    .out_frame_ready    (out_frame_ready),
    .out_frame_complete (out_frame_complete),
    .out_frame_width    (out_frame_width),
    .out_frame_height   (out_frame_height),
    .out_frame_number   (out_frame_number),
    .out_last_result    (out_last_result)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for nibble_video_packet_unpacker_unit: a directed request table, a wide line
// under an output hold, then random frames, flawed headers and noise. Depends on nvpu_pkg and the unit's RTL.
module tb_top;
  import nvpu_pkg::*;

  localparam int HDR_LEN      = 12;
  localparam int FRAME_STRIDE = 384;
  localparam int FRAME_ROWS   = 312;
  localparam int PKT_CAP      = 2048;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_WIDTH   = 64;
  localparam int RANDOM_REQS  = 140;

  localparam int OFS_FRAME = 2;
  localparam int OFS_LINE  = 4;
  localparam int OFS_WIDTH = 6;
  localparam int OFS_LINES = 8;
  localparam int OFS_BPP   = 9;
  localparam int OFS_ENC   = 10;

  localparam logic [7:0]  NIBBLE_BPP = 8'd4;
  localparam logic [15:0] RAW_ENC    = 16'd0;

  localparam logic [31:0] NIBBLE_ARGB [16] = '{
    32'hFF000000, 32'hFFFFFFFF, 32'hFF813338, 32'hFF75CEC8,
    32'hFF8E3C97, 32'hFF56AC4D, 32'hFF2E2C9B, 32'hFFEDF171,
    32'hFF8E5029, 32'hFF553800, 32'hFFC46C71, 32'hFF4A4A4A,
    32'hFF7B7B7B, 32'hFFA9FF9F, 32'hFF706DEB, 32'hFFB2B2B2
  };

  typedef enum int {
    FLAW_BPP, FLAW_ENC, FLAW_NO_WIDTH, FLAW_WIDE, FLAW_NO_LINES,
    FLAW_TALL, FLAW_SHORT, FLAW_CUT, FLAW_NOISE
  } flaw_t;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  addr;
    logic [31:0]        color;
    logic               accepted;
    logic               ready;
    logic               complete;
    logic [FW_W-1:0]    width;
    logic [FW_W-1:0]    height;
    logic [FRAME_W-1:0] frame;
    logic               last;
  } unpack_res_t;

  typedef struct packed {
    logic [7:0]       d;
    logic [LEN_W-1:0] len;
    logic             typed;
    unpack_res_t      want;
  } seed_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = '0;
  logic [LEN_W-1:0]   in_packet_length = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_result_kind;
  logic [ADDR_W-1:0]  out_pixel_address;
  logic [31:0]        out_pixel_color;
  logic               out_packet_accepted;
  logic               out_frame_ready;
  logic               out_frame_complete;
  logic [FW_W-1:0]    out_frame_width;
  logic [FW_W-1:0]    out_frame_height;
  logic [FRAME_W-1:0] out_frame_number;
  logic               out_last_result;

  nibble_video_packet_unpacker_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_packet_length    (in_packet_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_pixel_address   (out_pixel_address),
    .out_pixel_color     (out_pixel_color),
    .out_packet_accepted (out_packet_accepted),
    .out_frame_ready     (out_frame_ready),
    .out_frame_complete  (out_frame_complete),
    .out_frame_width     (out_frame_width),
    .out_frame_height    (out_frame_height),
    .out_frame_number    (out_frame_number),
    .out_last_result     (out_last_result)
  );

  always #1 clk = ~clk;

  // unpacker mirror
  logic [7:0]         hdr [HDR_LEN];
  logic [10:0]        byte_pos = '0;
  logic               hdr_ok = 1'b0;
  logic [7:0]         row = '0;
  logic [8:0]         col = '0;
  logic [15:0]        cur_frame = 16'hFFFF;
  logic [15:0]        lines_rx = '0;
  logic               ready_f = 1'b0;
  logic               complete_f = 1'b0;
  logic [FW_W-1:0]    width_seen = 9'd384;
  logic [FW_W-1:0]    height_seen = 9'd272;

  unpack_res_t step_res [3];
  int          step_n;
  unpack_res_t due_writes [$];
  unpack_res_t oldest;

  logic [7:0]  pkt [256];
  logic [15:0] frame_id = '0;
  seed_row_t   seed_rows [17];
  int          fails = 0;
  int          reqs_sent = 0;
  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  int          hold_ticket = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  function automatic logic [15:0] hdr_word(input int i);
    return {hdr[i+1], hdr[i]};
  endfunction

  function automatic unpack_res_t status_res(input logic acc, input logic rdy,
                                             input logic cmp, input logic [FW_W-1:0] w,
                                             input logic [FW_W-1:0] h,
                                             input logic [FRAME_W-1:0] f);
    unpack_res_t r;
    r = '0;
    r.kind     = KIND_STATUS;
    r.accepted = acc;
    r.ready    = rdy;
    r.complete = cmp;
    r.width    = w;
    r.height   = h;
    r.frame    = f;
    r.last     = 1'b1;
    return r;
  endfunction

  task automatic unpack_byte(input logic [7:0] d, input logic [LEN_W-1:0] len_raw);
    int len, w, lines, line, need, base;
    unpack_res_t r;
    len = (len_raw == 0) ? 1 : ((len_raw > PKT_CAP) ? PKT_CAP : int'(len_raw));
    step_n = 0;
    if (byte_pos < HDR_LEN) begin
      hdr[byte_pos] = d;
      if (byte_pos == HDR_LEN - 1) begin
        w     = hdr_word(OFS_WIDTH);
        lines = hdr[OFS_LINES];
        line  = hdr_word(OFS_LINE) & 16'h7FFF;
        need  = HDR_LEN + (w + 1) / 2 * lines;
        hdr_ok = hdr[OFS_BPP] == NIBBLE_BPP && hdr_word(OFS_ENC) == RAW_ENC &&
                 w >= 1 && w <= FRAME_STRIDE && lines >= 1 &&
                 line + lines <= FRAME_ROWS && len >= need;
        row = '0;
        col = '0;
      end
    end else if (hdr_ok && row < hdr[OFS_LINES]) begin
      w    = hdr_word(OFS_WIDTH);
      base = ((hdr_word(OFS_LINE) & 16'h7FFF) + row) * FRAME_STRIDE;
      r = '0;
      r.kind  = KIND_PIXEL;
      r.addr  = ADDR_W'(base + col);
      r.color = NIBBLE_ARGB[d[3:0]];
      step_res[step_n] = r;
      step_n = step_n + 1;
      if (col + 1 < w) begin
        r.addr  = ADDR_W'(base + col + 1);
        r.color = NIBBLE_ARGB[d[7:4]];
        step_res[step_n] = r;
        step_n = step_n + 1;
      end
      col = col + 2;
      if (col >= w) begin
        col = '0;
        row = row + 1;
      end
    end
    if (byte_pos + 1 >= len) begin
      if (hdr_ok) begin
        if (hdr_word(OFS_FRAME) != cur_frame) begin
          cur_frame = hdr_word(OFS_FRAME);
          lines_rx  = '0;
          ready_f   = 1'b0;
        end
        lines_rx   = lines_rx + hdr[OFS_LINES];
        width_seen = FW_W'(hdr_word(OFS_WIDTH));
        if (hdr[OFS_LINE+1][7]) begin
          height_seen = FW_W'((hdr_word(OFS_LINE) & 16'h7FFF) + hdr[OFS_LINES]);
          ready_f     = 1'b1;
          complete_f  = lines_rx >= height_seen;
        end
      end
      step_res[step_n] = status_res(hdr_ok, ready_f, complete_f, width_seen, height_seen,
                                    cur_frame);
      step_n   = step_n + 1;
      byte_pos = '0;
      hdr_ok   = 1'b0;
      row      = '0;
      col      = '0;
    end else begin
      byte_pos = byte_pos + 1;
    end
    for (int k = 0; k < step_n; k++) step_res[k].last = (k == step_n - 1);
  endtask

  task automatic send_req(input logic [7:0] d, input logic [LEN_W-1:0] len,
                          input logic typed, input unpack_res_t want);
    while (src_idle_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= d;
    in_packet_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reqs_sent = reqs_sent + 1;
    unpack_byte(d, len);
    if (typed) begin
      due_writes.push_back(want);
    end else begin
      for (int k = 0; k < step_n; k++) due_writes.push_back(step_res[k]);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_writes.size() != 0);
  endtask

  task automatic put_header(input logic [15:0] f, input logic [15:0] line_word,
                            input logic [15:0] w, input logic [7:0] lines,
                            input logic [7:0] bpp, input logic [15:0] enc);
    pkt[0]  = 8'($urandom);
    pkt[1]  = 8'($urandom);
    pkt[2]  = f[7:0];
    pkt[3]  = f[15:8];
    pkt[4]  = line_word[7:0];
    pkt[5]  = line_word[15:8];
    pkt[6]  = w[7:0];
    pkt[7]  = w[15:8];
    pkt[8]  = lines;
    pkt[9]  = bpp;
    pkt[10] = enc[7:0];
    pkt[11] = enc[15:8];
  endtask

  // now and then present another length, still past the current byte, on bytes that do not end the packet
  task automatic send_packet(input int n, input int jitter_pct);
    logic [LEN_W-1:0] len;
    for (int i = 0; i < n; i++) begin
      if (i >= HDR_LEN) pkt[i] = 8'($urandom);
      len = LEN_W'(n);
      if (i + 1 < n && $urandom_range(99) < jitter_pct) len = LEN_W'($urandom_range(4095, i + 2));
      send_req(pkt[i], len, 1'b0, '0);
    end
  endtask

  task automatic send_frame();
    int w, rows, top, line, n_lines, n;
    logic lastp;
    if ($urandom_range(2) != 0) frame_id = 16'($urandom);
    w    = $urandom_range(1, 9);
    rows = $urandom_range(1, 6);
    top  = ($urandom_range(3) == 0) ? $urandom_range(0, FRAME_ROWS - rows) : 0;
    line = top;
    while (line < top + rows) begin
      n_lines = $urandom_range(1, 3);
      if (line + n_lines > top + rows) n_lines = top + rows - line;
      lastp = (line + n_lines == top + rows);
      // drop a packet that is not the last of the frame now and then
      if (lastp || $urandom_range(5) != 0) begin
        put_header(frame_id, {lastp, 15'(line)}, 16'(w), 8'(n_lines), NIBBLE_BPP, RAW_ENC);
        n = HDR_LEN + (w + 1) / 2 * n_lines;
        if ($urandom_range(2) == 0) n = n + $urandom_range(1, 3);
        send_packet(n, 10);
      end
      line = line + n_lines;
    end
  endtask

  task automatic send_flawed();
    flaw_t flaw;
    int w, lines, line, need, n;
    logic [7:0] bpp;
    logic [15:0] enc;
    flaw  = flaw_t'($urandom_range(0, FLAW_NOISE));
    w     = $urandom_range(1, 9);
    lines = $urandom_range(1, 3);
    line  = $urandom_range(0, FRAME_ROWS - lines);
    bpp   = NIBBLE_BPP;
    enc   = RAW_ENC;
    case (flaw)
      FLAW_BPP: begin
        bpp = 8'($urandom);
        if (bpp == NIBBLE_BPP) bpp = ~bpp;
      end
      FLAW_ENC:      enc   = 16'($urandom_range(1, 65535));
      FLAW_NO_WIDTH: w     = 0;
      FLAW_WIDE:     w     = $urandom_range(FRAME_STRIDE + 1, 65535);
      FLAW_NO_LINES: lines = 0;
      FLAW_TALL:     line  = $urandom_range(FRAME_ROWS - lines + 1, 'h7FFF);
      default: ;
    endcase
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 16)) send_req(8'($urandom), LEN_W'($urandom), 1'b0, '0);
      if (byte_pos != 0) send_req(8'($urandom), LEN_W'(byte_pos + 1), 1'b0, '0);
    end else begin
      put_header(16'($urandom), {1'($urandom), 15'(line)}, 16'(w), 8'(lines), bpp, enc);
      need = HDR_LEN + (w + 1) / 2 * lines;
      n = need + $urandom_range(0, 2);
      if (flaw == FLAW_WIDE) n = HDR_LEN + $urandom_range(0, 6);
      if (flaw == FLAW_SHORT) n = need - 1;
      if (flaw == FLAW_CUT) n = $urandom_range(1, HDR_LEN - 1);
      send_packet(n, 0);
    end
  endtask

  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= snk_idle_on && ($urandom_range(99) < 9);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fails = fails + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (due_writes.size() == 0) begin
        $display("%0t: result kind %0b with nothing expected", $time, out_result_kind);
        fails = fails + 1;
      end else begin
        oldest = due_writes.pop_front();
        check_field("result_kind", 32'(oldest.kind), 32'(out_result_kind));
        check_field("pixel_address", 32'(oldest.addr), 32'(out_pixel_address));
        check_field("pixel_color", oldest.color, out_pixel_color);
        check_field("packet_accepted", 32'(oldest.accepted), 32'(out_packet_accepted));
        check_field("frame_ready", 32'(oldest.ready), 32'(out_frame_ready));
        check_field("frame_complete", 32'(oldest.complete), 32'(out_frame_complete));
        check_field("frame_width", 32'(oldest.width), 32'(out_frame_width));
        check_field("frame_height", 32'(oldest.height), 32'(out_frame_height));
        check_field("frame_number", 32'(oldest.frame), 32'(out_frame_number));
        check_field("last_result", 32'(oldest.last), 32'(out_last_result));
      end
    end
  end

  initial begin
    int n, base;
    for (int i = 0; i < HDR_LEN; i++) hdr[i] = '0;
    seed_rows = '{
      '{8'h00, 12'd0,   1'b1, status_res(1'b0, 1'b0, 1'b0, 9'd384, 9'd272, 16'hFFFF)},
      '{8'hFF, 12'hFFF, 1'b0, '0},
      '{8'hFF, 12'd15,  1'b0, '0},
      '{8'h00, 12'd15,  1'b0, '0},
      '{8'h00, 12'd15,  1'b0, '0},
      '{8'h37, 12'd15,  1'b0, '0},
      '{8'h81, 12'd15,  1'b0, '0},
      '{8'h03, 12'd15,  1'b0, '0},
      '{8'h00, 12'd15,  1'b0, '0},
      '{8'h01, 12'd15,  1'b0, '0},
      '{8'h04, 12'd15,  1'b0, '0},
      '{8'h00, 12'd15,  1'b0, '0},
      '{8'h00, 12'd15,  1'b0, '0},
      '{8'h10, 12'd15,  1'b0, '0},
      '{8'hF2, 12'd15,  1'b0, '0},
      '{8'h5A, 12'd15,  1'b0, '0},
      '{8'hFF, 12'd1,   1'b1, status_res(1'b0, 1'b1, 1'b0, 9'd3, 9'd312, 16'h0000)}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (seed_rows[i]) send_req(seed_rows[i].d, seed_rows[i].len, seed_rows[i].typed,
                                    seed_rows[i].want);
    pause_until_drained();

    // wide line while the receiver holds off
    hold_ticket = hold_ticket + 1;
    put_header(16'($urandom), {1'b0, 15'($urandom_range(0, FRAME_ROWS - 1))},
               16'(HOLD_WIDTH), 8'd1, NIBBLE_BPP, RAW_ENC);
    n = HDR_LEN + HOLD_WIDTH / 2;
    send_packet(n, 10);
    pause_until_drained();

    base = reqs_sent;
    while (reqs_sent - base < RANDOM_REQS) begin
      src_idle_on = (reqs_sent - base < 45) || (reqs_sent - base >= 95);
      snk_idle_on = src_idle_on;
      if ($urandom_range(3) == 0) send_flawed();
      else send_frame();
      if ($urandom_range(7) == 0) pause_until_drained();
    end

    pause_until_drained();
    repeat (16) @(posedge clk);
    if (fails == 0) $display("nibble_video_packet_unpacker_unit test passed");
    else $display("nibble_video_packet_unpacker_unit test failed");
    $finish;
  end

  initial begin
    #200000;
    $display("nibble_video_packet_unpacker_unit test failed");
    $finish;
  end

endmodule
